FILE: rtl/fwc_pkg.sv
// Shared types, constants and helpers for the four-channel PWM dimmer.
// No dependencies; fwc_fade, fwc_pwm and the top level refer to this package by scoped names.
`timescale 1ns / 1ps

package fwc_pkg;

	localparam int NUM_CH    = 4;
	localparam int CH_W      = 2;
	localparam int DUTY_W    = 7;
	localparam int CNT_W     = 7;
	localparam int TIME_W    = 21;
	localparam int PERIOD_W  = 20;
	localparam int STEPS_W   = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 20;

	localparam logic [CNT_W-1:0]  PWM_TOP    = 7'd100;
	localparam logic [TIME_W-1:0] TICK_US    = 21'd100;
	localparam logic [7:0]        DUTY_LIMIT = 8'd100;

	typedef enum logic {
		FUNC_TICK = 1'b0,
		FUNC_SET  = 1'b1
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FADE_ENABLE = 2'd0,
		CFG_FADE_PERIOD = 2'd1,
		CFG_FADE_STEPS  = 2'd2,
		CFG_UNUSED      = 2'd3
	} cfg_idx_t;

	// Duty writes issued by one fade step, one slot per channel.
	typedef struct packed {
		logic [NUM_CH-1:0]             we;
		logic [NUM_CH-1:0][DUTY_W-1:0] val;
	} fade_wr_t;

	// Clamp a requested duty to the limit of 100.
	function automatic logic [DUTY_W-1:0] clamp_duty(input logic [7:0] v);
		logic [7:0] c;
		c = (v > DUTY_LIMIT) ? DUTY_LIMIT : v;
		return c[DUTY_W-1:0];
	endfunction

endpackage

FILE: rtl/fwc_fade.sv
// Crossfade sequencer: time accumulator, progress count and active channel.
// Depends on fwc_pkg; emits per-channel duty writes as fwc_pkg::fade_wr_t.
`timescale 1ns / 1ps

module fwc_fade (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  logic [fwc_pkg::PERIOD_W-1:0]        period,
	input  logic [fwc_pkg::STEPS_W-1:0]         steps,
	output fwc_pkg::fade_wr_t                   fade_wr
);

	logic [fwc_pkg::TIME_W-1:0]  time_q;
	logic [fwc_pkg::STEPS_W-1:0] prog_q;
	logic [fwc_pkg::CH_W-1:0]    ch_q;

	logic [fwc_pkg::TIME_W-1:0]  time_sum;
	logic                        fire;
	logic [fwc_pkg::STEPS_W:0]   next_p;
	logic                        rot;
	logic [fwc_pkg::STEPS_W-1:0] new_prog;
	logic [fwc_pkg::CH_W-1:0]    new_ch;
	logic [fwc_pkg::CH_W-1:0]    nxt_ch;
	logic [fwc_pkg::STEPS_W-1:0] a_val;

	assign time_sum = time_q + fwc_pkg::TICK_US;
	assign fire     = !(time_sum < {1'b0, period});
	assign next_p   = {1'b0, prog_q} + 9'd1;
	assign rot      = !(next_p < {1'b0, steps});
	assign new_prog = rot ? '0 : next_p[fwc_pkg::STEPS_W-1:0];
	assign new_ch   = rot ? ch_q + 2'd1 : ch_q;
	assign nxt_ch   = new_ch + 2'd1;
	assign a_val    = steps - new_prog;

	always_comb begin
		fade_wr = '0;
		if (step && fire) begin
			// drop the outgoing channel before the new pair is written
			if (rot) begin
				fade_wr.we[ch_q]  = 1'b1;
				fade_wr.val[ch_q] = '0;
			end
			fade_wr.we[new_ch]  = 1'b1;
			fade_wr.val[new_ch] = fwc_pkg::clamp_duty(a_val);
			fade_wr.we[nxt_ch]  = 1'b1;
			fade_wr.val[nxt_ch] = fwc_pkg::clamp_duty(new_prog);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
			prog_q <= '0;
			ch_q   <= '0;
		end else if (step) begin
			if (fire) begin
				time_q <= '0;
				prog_q <= new_prog;
				ch_q   <= new_ch;
			end else begin
				time_q <= time_sum;
			end
		end
	end

endmodule

FILE: rtl/fwc_pwm.sv
// PWM core: shared counter, four duty compare registers and the LED register.
// Depends on fwc_pkg; takes set writes from the input word and fade writes from fwc_fade.
`timescale 1ns / 1ps

module fwc_pwm (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              tick,
	input  logic                              set,
	input  logic [2:0]                        set_ch,
	input  logic [7:0]                        set_duty,
	input  fwc_pkg::fade_wr_t                 fade_wr,
	output logic [fwc_pkg::NUM_CH-1:0]        leds
);

	logic [fwc_pkg::CNT_W-1:0]                       cnt_q;
	logic [fwc_pkg::NUM_CH-1:0][fwc_pkg::DUTY_W-1:0] duty_q;
	logic [fwc_pkg::NUM_CH-1:0]                      led_q;
	logic [fwc_pkg::NUM_CH-1:0]                      cmp;

	always_comb begin
		for (int i = 0; i < fwc_pkg::NUM_CH; i++) begin
			cmp[i] = duty_q[i] > cnt_q;
		end
	end

	// A set word repeats the held LED state.
	assign leds = tick ? cmp : led_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			duty_q <= '0;
			led_q  <= '0;
		end else if (tick) begin
			led_q <= cmp;
			cnt_q <= (cnt_q > fwc_pkg::PWM_TOP) ? '0 : cnt_q + 7'd1;
			for (int i = 0; i < fwc_pkg::NUM_CH; i++) begin
				if (fade_wr.we[i]) begin
					duty_q[i] <= fade_wr.val[i];
				end
			end
		end else if (set && !set_ch[2]) begin
			duty_q[set_ch[1:0]] <= fwc_pkg::clamp_duty(set_duty);
		end
	end

endmodule

FILE: rtl/four_channel_pwm_with_crossfade.sv
// Four-channel PWM LED dimmer with crossfade: input register, core, result register.
// Depends on fwc_pkg, fwc_fade and fwc_pwm.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall, func, channel, duty): a tick word
//   (func = 0) samples all four channels against the shared PWM counter and
//   advances the counter and, when enabled, the crossfade; a set word
//   (func = 1) writes one channel duty, clamped to 100, channels above 3 drop.
//   Output channel (out_valid / out_stall, led_levels): one word per input
//   word, in order. A set word returns the LED state of the last tick.
//   Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0 is
//   fade enable, 1 the fade period in microseconds, 2 the step count; index 3
//   is ignored. cfg_ready is always high; write only while the block is idle.
// Timing
//   Each word passes the input register, then the result register.
//   Throughput is one word per cycle while out_stall is low, set by the single registered pass
//   through the compare and fade-step logic.
// Reset
//   arst_n clears counter, duties, LED state, fade state and config registers.
// Backpressure
//   While out_stall holds a full result register, one more word sits in the
//   input register; in_stall rises only when both are full.

module four_channel_pwm_with_crossfade (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              func,
	input  logic [2:0]                        channel,
	input  logic [7:0]                        duty,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [3:0]                        led_levels,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fwc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fwc_pkg::CFG_DAT_W-1:0]     cfg_data
);

	// config registers
	logic                             fade_en_q;
	logic [fwc_pkg::PERIOD_W-1:0]     period_q;
	logic [fwc_pkg::STEPS_W-1:0]      steps_q;

	// input register
	logic                             valid_s1;
	logic                             func_s1;
	logic [2:0]                       ch_s1;
	logic [7:0]                       duty_s1;

	// result register
	logic                             out_valid_q;
	logic [fwc_pkg::NUM_CH-1:0]       led_q;

	logic                             out_free;
	logic                             take_s1;
	logic                             in_take;
	logic                             tick;
	logic                             set;
	logic [fwc_pkg::NUM_CH-1:0]       leds;
	fwc_pkg::fade_wr_t                fade_wr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_en_q <= 1'b0;
			period_q  <= '0;
			steps_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fwc_pkg::CFG_FADE_ENABLE: fade_en_q <= cfg_data[0];
				fwc_pkg::CFG_FADE_PERIOD: period_q  <= cfg_data;
				fwc_pkg::CFG_FADE_STEPS:  steps_q   <= cfg_data[fwc_pkg::STEPS_W-1:0];
				default: ;
			endcase
		end
	end

	// The result register frees when empty or when its word leaves this cycle.
	assign out_free = !out_valid_q || !out_stall;
	assign take_s1  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (take_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// hold the payload while the word waits
	always_ff @(posedge clk) begin
		if (in_take) begin
			func_s1 <= func;
			ch_s1   <= channel;
			duty_s1 <= duty;
		end
	end

	assign tick = take_s1 && (func_s1 == fwc_pkg::FUNC_TICK);
	assign set  = take_s1 && (func_s1 == fwc_pkg::FUNC_SET);

	fwc_fade u_fade (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (tick && fade_en_q),
		.period  (period_q),
		.steps   (steps_q),
		.fade_wr (fade_wr)
	);

	fwc_pwm u_pwm (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick),
		.set      (set),
		.set_ch   (ch_s1),
		.set_duty (duty_s1),
		.fade_wr  (fade_wr),
		.leds     (leds)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= take_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			led_q <= leds;
		end
	end

	assign out_valid  = out_valid_q;
	assign led_levels = led_q;

endmodule

FILE: rtl/fwc_checker.sv
// Port-level checks for the four-channel PWM dimmer, bound to the top level.
// Depends on four_channel_pwm_with_crossfade.
`timescale 1ns / 1ps

module fwc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [3:0]                        led_levels,
	input logic                              cfg_valid,
	input logic                              cfg_ready
);

	// input backs up only when a result is held by the receiver
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a stalled output word");

	// a stalled output word stays and holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(led_levels)))
		else $error("stalled output word changed or dropped");

	// an output word leaves only through an accept
	a_out_leave: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("output word vanished without accept");

	// config writes are always taken
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

endmodule

bind four_channel_pwm_with_crossfade fwc_checker u_fwc_checker (.*);

FILE: sim/tb_four_channel_pwm_with_crossfade.sv
// Self-checking testbench for the four-channel PWM dimmer with crossfade.
// Depends on fwc_pkg and the four_channel_pwm_with_crossfade RTL; a scoreboard
// class predicts led_levels for each accepted word and checks the output.
`timescale 1ns / 1ps

// Predicts the LED pattern of the dimmer and holds the patterns still owed.
class dimmer_scoreboard;
	// register copies
	bit        fade_on;
	bit [19:0] period_us;
	bit [7:0]  step_limit;
	// core state copies
	bit [6:0]  pwm_count;
	bit [6:0]  duty_cmp [4];
	bit [3:0]  led_state;
	bit [20:0] fade_time;
	bit [7:0]  fade_progress;
	bit [1:0]  fade_ch;
	bit [3:0]  expected_levels [$];
	int        errors;

	function void write_reg(fwc_pkg::cfg_idx_t idx, logic [fwc_pkg::CFG_DAT_W-1:0] data);
		case (idx)
			fwc_pkg::CFG_FADE_ENABLE: fade_on = data[0];
			fwc_pkg::CFG_FADE_PERIOD: period_us = data;
			fwc_pkg::CFG_FADE_STEPS: step_limit = data[7:0];
			default: ;
		endcase
	endfunction

	function void load_duty(int ch, int val);
		if (ch < fwc_pkg::NUM_CH)
			duty_cmp[ch] = 7'((val > fwc_pkg::DUTY_LIMIT) ? fwc_pkg::DUTY_LIMIT : val);
	endfunction

	function void step_fade();
		int       nxt;
		bit [1:0] partner;
		fade_time = fade_time + fwc_pkg::TICK_US;
		if (fade_time < period_us)
			return;
		nxt = fade_progress + 1;
		if (nxt >= step_limit) begin
			load_duty(fade_ch, 0);
			fade_ch = fade_ch + 2'd1;
			nxt = 0;
		end
		fade_progress = 8'(nxt);
		partner = fade_ch + 2'd1;
		load_duty(fade_ch, step_limit - fade_progress);
		load_duty(partner, fade_progress);
		fade_time = '0;
	endfunction

	function void note_word(logic f, logic [2:0] ch, logic [7:0] d);
		bit [3:0] lv;
		if (f == fwc_pkg::FUNC_SET) begin
			load_duty(ch, d);
		end else begin
			lv = '0;
			for (int i = 0; i < fwc_pkg::NUM_CH; i++)
				lv[i] = duty_cmp[i] > pwm_count;
			led_state = lv;
			if (pwm_count > fwc_pkg::PWM_TOP)
				pwm_count = '0;
			else
				pwm_count = pwm_count + 7'd1;
			if (fade_on)
				step_fade();
		end
		expected_levels.push_back(led_state);
	endfunction

	function void check_level(logic [3:0] got);
		bit [3:0] want;
		if (expected_levels.size() == 0) begin
			$display("%0t: unexpected led_levels word, expected none, got %b", $time, got);
			errors++;
			return;
		end
		want = expected_levels.pop_front();
		if (got !== want) begin
			$display("%0t: led_levels mismatch, expected %b, got %b", $time, want, got);
			errors++;
		end
	endfunction

	function int pending();
		return expected_levels.size();
	endfunction
endclass

module tb_four_channel_pwm_with_crossfade;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic                          func = fwc_pkg::FUNC_TICK;
	logic [2:0]                    channel = '0;
	logic [7:0]                    duty = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [3:0]                    led_levels;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [fwc_pkg::CFG_IDX_W-1:0] cfg_index = fwc_pkg::CFG_FADE_ENABLE;
	logic [fwc_pkg::CFG_DAT_W-1:0] cfg_data = '0;

	// idle percentages for the sender and the receiver, changed per phase
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	dimmer_scoreboard led_board = new();

	four_channel_pwm_with_crossfade i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.channel    (channel),
		.duty       (duty),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.led_levels (led_levels),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Stall the receiver at random; the rate follows the current phase.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Watch all three channels at the edge. Inputs are noted before outputs so a
	// word always has its prediction queued before its result can show up.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				led_board.write_reg(fwc_pkg::cfg_idx_t'(cfg_index), cfg_data);
			if (in_valid && !in_stall)
				led_board.note_word(func, channel, duty);
			if (out_valid && !out_stall)
				led_board.check_level(led_levels);
		end
	end

	// Present one word and hold it until the block takes it. An optional idle
	// gap goes first; valid only drops when a gap is actually taken, so back to
	// back words keep valid high without a low/high pair in one step.
	task automatic send_word(input logic f, input logic [2:0] ch, input logic [7:0] d);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		func     <= f;
		channel  <= ch;
		duty     <= d;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid and hold off until every owed LED word has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (led_board.pending() != 0)
			@(posedge clk);
	endtask

	// Put one register write on the config channel; valid stays high for the next.
	task automatic put_reg(input fwc_pkg::cfg_idx_t idx,
			input logic [fwc_pkg::CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Load a full fade setting. Junk goes to the unused index and to the upper
	// bits of the narrow registers, which the block must ignore.
	task automatic load_setting(input bit en, input bit [19:0] period, input bit [7:0] steps);
		logic [fwc_pkg::CFG_DAT_W-1:0] d;
		put_reg(fwc_pkg::CFG_UNUSED, fwc_pkg::CFG_DAT_W'($urandom));
		d = fwc_pkg::CFG_DAT_W'($urandom);
		d[0] = en;
		put_reg(fwc_pkg::CFG_FADE_ENABLE, d);
		put_reg(fwc_pkg::CFG_FADE_PERIOD, period);
		d = fwc_pkg::CFG_DAT_W'($urandom);
		d[7:0] = steps;
		put_reg(fwc_pkg::CFG_FADE_STEPS, d);
		cfg_valid <= 1'b0;
	endtask

	// Random words: mostly ticks to push the counter and the fade along, the
	// rest duty writes over all eight channel codes. Halfway through, hold the
	// sender until the output side has fully caught up.
	task automatic send_random(input int count);
		int          pick;
		logic [2:0]  ch;
		logic [7:0]  d;
		for (int n = 0; n < count; n++) begin
			if (n == count / 2)
				drain_results();
			if ($urandom_range(99) < 80) begin
				send_word(fwc_pkg::FUNC_TICK, 3'($urandom), 8'($urandom));
			end else begin
				ch = 3'($urandom);
				pick = $urandom_range(2);
				if (pick == 0)
					d = 8'($urandom);
				else if (pick == 1)
					d = 8'($urandom_range(110, 90));
				else
					d = 8'($urandom_range(20));
				send_word(fwc_pkg::FUNC_SET, ch, d);
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase 0, fade off: duty extremes, clamping, dropped channels, ticks.
		send_idle_pct  = 36;
		recv_stall_pct = 71;
		load_setting(1'b0, 20'd0, 8'd0);
		send_word(fwc_pkg::FUNC_TICK, 3'd0, 8'd0);
		send_word(fwc_pkg::FUNC_SET, 3'd0, 8'd0);
		send_word(fwc_pkg::FUNC_SET, 3'd1, 8'd255);
		send_word(fwc_pkg::FUNC_SET, 3'd2, 8'd100);
		send_word(fwc_pkg::FUNC_SET, 3'd3, 8'd101);
		send_word(fwc_pkg::FUNC_SET, 3'd4, 8'd255);
		send_word(fwc_pkg::FUNC_SET, 3'd5, 8'd50);
		send_word(fwc_pkg::FUNC_SET, 3'd6, 8'd1);
		send_word(fwc_pkg::FUNC_SET, 3'd7, 8'd99);
		repeat (4)
			send_word(fwc_pkg::FUNC_TICK, 3'd7, 8'd255);
		send_word(fwc_pkg::FUNC_SET, 3'd3, 8'd1);
		send_word(fwc_pkg::FUNC_SET, 3'd2, 8'd99);
		send_word(fwc_pkg::FUNC_SET, 3'd0, 8'd2);
		repeat (6)
			send_word(fwc_pkg::FUNC_TICK, 3'd0, 8'd0);
		send_random(150);
		drain_results();

		// Zero steps, zero period: every tick takes a step and rotates.
		load_setting(1'b1, 20'd0, 8'd0);
		send_random(150);
		drain_results();

		load_setting(1'b1, 20'd100, 8'd10);
		send_random(150);
		drain_results();

		// Largest step count: the dimming channel clamps at 100.
		load_setting(1'b1, 20'd350, 8'd255);
		send_random(150);
		drain_results();

		send_idle_pct  = 71;
		recv_stall_pct = 36;
		load_setting(1'b1, 20'd200, 8'd50);
		send_random(150);
		drain_results();

		// Lower the step count under the progress reached: next step rotates.
		load_setting(1'b1, 20'd200, 8'd3);
		send_random(150);
		drain_results();

		// Fade off: the fade state must hold through ticks.
		load_setting(1'b0, 20'd300, 8'd20);
		send_random(150);
		drain_results();

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		load_setting(1'b1, 20'hFFFFF, 8'd1);
		send_random(150);
		drain_results();

		load_setting(1'b1, 20'd0, 8'd255);
		send_random(150);
		drain_results();

		load_setting(1'b1, 20'd700, 8'd101);
		send_random(150);
		drain_results();

		// Leave room for any stray word past the last expected one.
		repeat (8) @(posedge clk);
		if (led_board.pending() != 0) begin
			$display("%0t: %0d LED words never arrived, expected %b first, got none", $time,
				led_board.pending(), led_board.expected_levels[0]);
			led_board.errors++;
		end
		if (led_board.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#5_000_000;
		$display("%0t: timeout", $time);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: four_channel_pwm_with_crossfade.f
rtl/fwc_pkg.sv
rtl/fwc_fade.sv
rtl/fwc_pwm.sv
rtl/four_channel_pwm_with_crossfade.sv
rtl/fwc_checker.sv
sim/tb_four_channel_pwm_with_crossfade.sv
